// ===== design/brmv_pkg.sv =====
package brmv_pkg;

    localparam int DIV_W = 56;
    localparam int DSR_W = 17;
    localparam int ITER_W = 6;
    localparam int IDX_W = 17;
    localparam int MUL_W = 24;
    localparam int WORD_W = 80;

    localparam logic [10:0] GRID_MIN = 11'd16;
    localparam logic [10:0] GRID_MAX = 11'd1440;

    localparam logic [1:0] REG_GRID = 2'd0;
    localparam logic [1:0] REG_MIN_COUNT = 2'd1;
    localparam logic [1:0] REG_MAX_VAR = 2'd2;

    localparam logic [1:0] STAT_UPD = 2'd0;
    localparam logic [1:0] STAT_HIT = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_STRIDE,
        S_AZB,
        S_ELB,
        S_IDX_MUL,
        S_IDX,
        S_READ,
        S_EVAL,
        S_SQ,
        S_PLO,
        S_PHI,
        S_PACC,
        S_VLO,
        S_VHI,
        S_T1A,
        S_T1B,
        S_T2,
        S_Q,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== design/brmv_div.sv =====
module brmv_div (
    input  logic                clk,
    input  logic                rst_n,
    input  brmv_pkg::div_req_t  req,
    output brmv_pkg::div_rsp_t  rsp
);

    logic                          run_reg;
    logic                          done_reg;
    logic [brmv_pkg::ITER_W-1:0]   cnt_reg;
    logic [brmv_pkg::DSR_W-1:0]    rem_reg;
    logic [brmv_pkg::DSR_W-1:0]    dsr_reg;
    logic [brmv_pkg::DIV_W-1:0]    dvd_reg;
    logic [brmv_pkg::DIV_W-1:0]    quot_reg;

    logic [brmv_pkg::DSR_W:0]      trial;
    logic [brmv_pkg::DSR_W:0]      diff;
    logic                          ge;
    logic [brmv_pkg::DSR_W-1:0]    rem_next;

    // one quotient bit a cycle, dividend comes left aligned
    always_comb
    begin
        trial = {rem_reg, dvd_reg[brmv_pkg::DIV_W-1]};
        diff = trial - {1'b0, dsr_reg};
        ge = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? diff[brmv_pkg::DSR_W-1:0] : trial[brmv_pkg::DSR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= req.iters;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == brmv_pkg::ITER_W'(1))
                begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            dvd_reg <= req.dividend;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[brmv_pkg::DIV_W-2:0], 1'b0};
            quot_reg <= {quot_reg[brmv_pkg::DIV_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== design/brmv_mem.sv =====
module brmv_mem #(
    parameter int DEPTH = 32768,
    parameter int AW = 15,
    parameter int W = 80
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/binned_running_mean_variance.sv =====
// channel   direction  handshake          word
// config    in         cfg_we             cfg_index, cfg_data
// item      in         start & !busy      op, azimuth, elevation, sample
// result    out        done (one cycle)   status, mean_out, count_out
//
// after reset a clearing pass writes zero to all CELL_COUNT cells, one a cycle,
// with busy high; config writes are taken during it.
// a query runs three divider passes (11, 13 and 11 bits) for the bin index, then
// the index multiply and the read. an out of range word ends after the index step.
// an update adds four more divider passes (56, 56, 56 and 24 bits) plus the
// multiply steps.
// one word at a time: busy stays high until its result strobe; the receiver cannot stall.
module binned_running_mean_variance #(
    parameter int CELL_COUNT = 32768
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [39:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [12:0]        azimuth,
    input  logic [10:0]        elevation,
    input  logic signed [23:0] sample,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [23:0] mean_out,
    output logic [15:0]        count_out
);

    localparam int AW = $clog2(CELL_COUNT);

    brmv_pkg::state_t state_reg, state_next;

    logic [10:0] grid_reg;
    logic [15:0] minc_reg;
    logic [39:0] maxv_reg;

    logic        op_reg;
    logic [12:0] az_reg;
    logic [10:0] el_reg;
    logic [23:0] smp_reg;

    logic [AW-1:0] clr_reg;
    logic [10:0]   stride_reg;
    logic [12:0]   azb_reg;
    logic [10:0]   elb_reg;
    logic [AW-1:0] idx_reg;

    logic [23:0] ad_reg;
    logic        neg_reg;
    logic [23:0] sqhi_reg;
    logic [63:0] acc_reg;
    logic [55:0] vacc_reg;
    logic [55:0] t1_reg;
    logic [55:0] t2_reg;
    logic [23:0] q_reg;
    logic [47:0] prod_reg;

    logic        done_reg;
    logic [1:0]  status_reg;
    logic [23:0] mean_reg;
    logic [15:0] count_reg;

    logic [brmv_pkg::MUL_W-1:0] mul_a, mul_b;
    brmv_pkg::div_req_t div_req;
    brmv_pkg::div_rsp_t div_rsp;

    logic                        mem_we, mem_re;
    logic [AW-1:0]               mem_waddr;
    logic [brmv_pkg::WORD_W-1:0] mem_wdata, mem_rdata;

    logic [10:0]               g;
    logic [brmv_pkg::IDX_W-1:0] idx;
    logic                      idx_ok;
    logic [15:0]               cnt_rd;
    logic [23:0]               mean_rd;
    logic [39:0]               var_rd;
    logic [16:0]               n1;
    logic [24:0]               d;
    logic [24:0]               d_abs;
    logic [56:0]               vsum;
    logic [39:0]               var_new;
    logic [23:0]               mean_new;
    logic [15:0]               cnt_new;
    logic                      hit;

    assign cnt_rd = mem_rdata[15:0];
    assign mean_rd = mem_rdata[39:16];
    assign var_rd = mem_rdata[79:40];
    assign n1 = {1'b0, cnt_rd} + 17'd1;

    always_comb
    begin
        if (grid_reg < brmv_pkg::GRID_MIN)
        begin
            g = brmv_pkg::GRID_MIN;
        end
        else if (grid_reg > brmv_pkg::GRID_MAX)
        begin
            g = brmv_pkg::GRID_MAX;
        end
        else
        begin
            g = grid_reg;
        end
    end

    assign idx = prod_reg[brmv_pkg::IDX_W-1:0] + brmv_pkg::IDX_W'(elb_reg);
    assign idx_ok = (idx < brmv_pkg::IDX_W'(CELL_COUNT));

    assign d = {smp_reg[23], smp_reg} - {mean_rd[23], mean_rd};
    assign d_abs = d[24] ? (25'd0 - d) : d;

    assign vsum = {1'b0, t1_reg} + {1'b0, t2_reg};
    assign var_new = (|vsum[56:40]) ? {40{1'b1}} : vsum[39:0];
    assign mean_new = neg_reg ? (mean_rd - q_reg) : (mean_rd + q_reg);
    assign cnt_new = (cnt_rd == 16'hFFFF) ? cnt_rd : (cnt_rd + 16'd1);
    assign hit = (cnt_rd > minc_reg) && (var_rd <= maxv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= 11'd16;
            minc_reg <= '0;
            maxv_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                brmv_pkg::REG_GRID:      grid_reg <= cfg_data[10:0];
                brmv_pkg::REG_MIN_COUNT: minc_reg <= cfg_data[15:0];
                brmv_pkg::REG_MAX_VAR:   maxv_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brmv_pkg::S_CLEAR;
            clr_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= 1'b0;
            if (state_reg == brmv_pkg::S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if ((state_reg == brmv_pkg::S_IDX && !idx_ok)
                || (state_reg == brmv_pkg::S_EVAL && op_reg)
                || state_reg == brmv_pkg::S_WRITE)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // datapath registers, stepped by the sequencer state
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            brmv_pkg::S_IDLE:
            begin
                op_reg <= op;
                az_reg <= azimuth;
                el_reg <= elevation;
                smp_reg <= sample;
            end
            brmv_pkg::S_STRIDE: stride_reg <= div_rsp.quot[10:0];
            brmv_pkg::S_AZB:    azb_reg <= div_rsp.quot[12:0];
            brmv_pkg::S_ELB:    elb_reg <= div_rsp.quot[10:0];
            brmv_pkg::S_IDX:
            begin
                idx_reg <= idx[AW-1:0];
                if (!idx_ok)
                begin
                    status_reg <= brmv_pkg::STAT_RANGE;
                    mean_reg <= '0;
                    count_reg <= '0;
                end
            end
            brmv_pkg::S_EVAL:
            begin
                ad_reg <= d_abs[23:0];
                neg_reg <= d[24];
                status_reg <= hit ? brmv_pkg::STAT_HIT : brmv_pkg::STAT_MISS;
                mean_reg <= hit ? mean_rd : 24'd0;
                count_reg <= cnt_rd;
            end
            brmv_pkg::S_PLO:  sqhi_reg <= prod_reg[47:24];
            brmv_pkg::S_PHI:  acc_reg <= {16'd0, prod_reg};
            brmv_pkg::S_PACC: acc_reg <= acc_reg + {prod_reg[39:0], 24'd0};
            brmv_pkg::S_VLO:  vacc_reg <= {8'd0, prod_reg};
            brmv_pkg::S_VHI:  vacc_reg <= vacc_reg + {prod_reg[35:0], 20'd0};
            brmv_pkg::S_T1B:
            begin
                if (div_rsp.done)
                begin
                    t1_reg <= div_rsp.quot;
                end
            end
            brmv_pkg::S_T2:
            begin
                if (div_rsp.done)
                begin
                    t2_reg <= div_rsp.quot;
                end
            end
            brmv_pkg::S_Q:
            begin
                if (div_rsp.done)
                begin
                    q_reg <= div_rsp.quot[23:0];
                end
            end
            brmv_pkg::S_WRITE:
            begin
                status_reg <= brmv_pkg::STAT_UPD;
                mean_reg <= '0;
                count_reg <= cnt_new;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        div_req = '0;
        mul_a = '0;
        mul_b = '0;
        mem_we = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {var_new, mean_new, cnt_new};
        mem_re = 1'b0;
        case (state_reg)
            brmv_pkg::S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == AW'(CELL_COUNT - 1))
                begin
                    state_next = brmv_pkg::S_IDLE;
                end
            end
            brmv_pkg::S_IDLE:
            begin
                if (start)
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = {brmv_pkg::GRID_MAX, 45'd0};
                    div_req.divisor = {6'd0, g};
                    div_req.iters = 6'd11;
                    state_next = brmv_pkg::S_STRIDE;
                end
            end
            brmv_pkg::S_STRIDE:
            begin
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = {az_reg, 43'd0};
                    div_req.divisor = {6'd0, g};
                    div_req.iters = 6'd13;
                    state_next = brmv_pkg::S_AZB;
                end
            end
            brmv_pkg::S_AZB:
            begin
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = {el_reg, 45'd0};
                    div_req.divisor = {6'd0, g};
                    div_req.iters = 6'd11;
                    state_next = brmv_pkg::S_ELB;
                end
            end
            brmv_pkg::S_ELB:
            begin
                if (div_rsp.done)
                begin
                    state_next = brmv_pkg::S_IDX_MUL;
                end
            end
            brmv_pkg::S_IDX_MUL:
            begin
                mul_a = {11'd0, azb_reg};
                mul_b = {13'd0, stride_reg};
                state_next = brmv_pkg::S_IDX;
            end
            brmv_pkg::S_IDX:
            begin
                mem_re = idx_ok;
                state_next = idx_ok ? brmv_pkg::S_READ : brmv_pkg::S_IDLE;
            end
            brmv_pkg::S_READ: state_next = brmv_pkg::S_EVAL;
            brmv_pkg::S_EVAL: state_next = op_reg ? brmv_pkg::S_IDLE : brmv_pkg::S_SQ;
            brmv_pkg::S_SQ:
            begin
                mul_a = ad_reg;
                mul_b = ad_reg;
                state_next = brmv_pkg::S_PLO;
            end
            brmv_pkg::S_PLO:
            begin
                mul_a = prod_reg[23:0];
                mul_b = {8'd0, cnt_rd};
                state_next = brmv_pkg::S_PHI;
            end
            brmv_pkg::S_PHI:
            begin
                mul_a = sqhi_reg;
                mul_b = {8'd0, cnt_rd};
                state_next = brmv_pkg::S_PACC;
            end
            brmv_pkg::S_PACC:
            begin
                mul_a = {4'd0, var_rd[19:0]};
                mul_b = {8'd0, cnt_rd};
                state_next = brmv_pkg::S_VLO;
            end
            brmv_pkg::S_VLO:
            begin
                mul_a = {4'd0, var_rd[39:20]};
                mul_b = {8'd0, cnt_rd};
                // d*d*n/256, first of the two divisions by n+1
                div_req.start = 1'b1;
                div_req.dividend = acc_reg[63:8];
                div_req.divisor = n1;
                div_req.iters = 6'd56;
                state_next = brmv_pkg::S_VHI;
            end
            brmv_pkg::S_VHI: state_next = brmv_pkg::S_T1A;
            brmv_pkg::S_T1A:
            begin
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = div_rsp.quot;
                    div_req.divisor = n1;
                    div_req.iters = 6'd56;
                    state_next = brmv_pkg::S_T1B;
                end
            end
            brmv_pkg::S_T1B:
            begin
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = vacc_reg;
                    div_req.divisor = n1;
                    div_req.iters = 6'd56;
                    state_next = brmv_pkg::S_T2;
                end
            end
            brmv_pkg::S_T2:
            begin
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = {ad_reg, 32'd0};
                    div_req.divisor = n1;
                    div_req.iters = 6'd24;
                    state_next = brmv_pkg::S_Q;
                end
            end
            brmv_pkg::S_Q:
            begin
                if (div_rsp.done)
                begin
                    state_next = brmv_pkg::S_WRITE;
                end
            end
            brmv_pkg::S_WRITE:
            begin
                // read data still holds the old cell, nothing else reads meanwhile
                mem_we = 1'b1;
                state_next = brmv_pkg::S_IDLE;
            end
            default: state_next = brmv_pkg::S_IDLE;
        endcase
    end

    brmv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    brmv_mem #(
        .DEPTH (CELL_COUNT),
        .AW    (AW),
        .W     (brmv_pkg::WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign busy = (state_reg != brmv_pkg::S_IDLE);
    assign done = done_reg;
    assign status = status_reg;
    assign mean_out = mean_reg;
    assign count_out = count_reg;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result strobes in a row");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == brmv_pkg::STAT_RANGE |-> mean_out == '0 && count_out == '0)
        else $error("out of range result carries data");

    a_upd_mean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == brmv_pkg::STAT_UPD |-> mean_out == '0)
        else $error("update result carries a mean");

endmodule
